FILE: src/rau_pkg.sv
package rau_pkg;

  localparam int unsigned WideW = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_COMBINE,
    S_GCD_INIT,
    S_GCD_STEP,
    S_GCD_NEXT,
    S_DIVN_INIT,
    S_DIVN_STEP,
    S_DIVD_INIT,
    S_DIVD_STEP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic [1:0]  status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic combine;
    logic gcd_init;
    logic div_step;
    logic gcd_next;
    logic divn_init;
    logic divd_init;
    logic finish;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic early_exit;  // zero input denominator
    logic fail;        // overflow or zero input or result denominator
    logic y_zero;      // Euclid remainder reached zero
    logic div_last;    // last divider step
  } stat_t;

endpackage

FILE: src/rau_ctrl.sv
module rau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  rau_pkg::stat_t stat_i,
  output rau_pkg::ctrl_t ctrl_o,
  output logic           busy,
  output logic           done_o
);

  rau_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::S_IDLE:      if (start) state_d = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1:      state_d = stat_i.early_exit ? rau_pkg::S_DONE : rau_pkg::S_MUL2;
      rau_pkg::S_MUL2:      state_d = rau_pkg::S_COMBINE;
      rau_pkg::S_COMBINE:   state_d = rau_pkg::S_GCD_INIT;
      rau_pkg::S_GCD_INIT:  begin
        if (stat_i.fail) state_d = rau_pkg::S_DONE;
        else if (stat_i.y_zero) state_d = rau_pkg::S_DIVN_INIT;
        else state_d = rau_pkg::S_GCD_STEP;
      end
      rau_pkg::S_GCD_STEP:  if (stat_i.div_last) state_d = rau_pkg::S_GCD_NEXT;
      rau_pkg::S_GCD_NEXT:  state_d = stat_i.y_zero ? rau_pkg::S_DIVN_INIT
                                                    : rau_pkg::S_GCD_STEP;
      rau_pkg::S_DIVN_INIT: state_d = rau_pkg::S_DIVN_STEP;
      rau_pkg::S_DIVN_STEP: if (stat_i.div_last) state_d = rau_pkg::S_DIVD_INIT;
      rau_pkg::S_DIVD_INIT: state_d = rau_pkg::S_DIVD_STEP;
      rau_pkg::S_DIVD_STEP: if (stat_i.div_last) state_d = rau_pkg::S_DONE;
      rau_pkg::S_DONE:      state_d = rau_pkg::S_IDLE;
      default:              state_d = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy = (state_q != rau_pkg::S_IDLE);
    done_o = (state_q == rau_pkg::S_DONE);
    case (state_q)
      rau_pkg::S_IDLE:      ctrl_o.load = start;
      rau_pkg::S_MUL1:      ctrl_o.mul1 = 1'b1;
      rau_pkg::S_MUL2:      ctrl_o.mul2 = 1'b1;
      rau_pkg::S_COMBINE:   ctrl_o.combine = 1'b1;
      rau_pkg::S_GCD_INIT:  ctrl_o.gcd_init = 1'b1;
      rau_pkg::S_GCD_STEP,
      rau_pkg::S_DIVN_STEP,
      rau_pkg::S_DIVD_STEP: ctrl_o.div_step = 1'b1;
      rau_pkg::S_GCD_NEXT:  ctrl_o.gcd_next = 1'b1;
      rau_pkg::S_DIVN_INIT: ctrl_o.divn_init = 1'b1;
      rau_pkg::S_DIVD_INIT: ctrl_o.divd_init = 1'b1;
      rau_pkg::S_DONE:      ctrl_o.finish = 1'b1;
      default:              ctrl_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("done not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(ctrl_o))
    else $error("multiple datapath commands");

endmodule

FILE: src/rau_dp.sv
module rau_dp #(
  parameter int unsigned OperandW = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rau_pkg::req_t  req_i,
  input  rau_pkg::ctrl_t ctrl_i,
  output rau_pkg::stat_t stat_o,
  output rau_pkg::rsp_t  rsp_o
);

  localparam int unsigned W = rau_pkg::WideW;
  localparam int unsigned CntW = $clog2(W);

  logic [1:0]         op_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [W-1:0] x_q, y_q, d_q;
  logic [W-1:0]       mn_q, md_q, gx_q, gy_q;
  logic               nneg_q, dneg_q, fail_q;
  logic [1:0]         st_q;
  // shared restoring divider
  logic [W-1:0]       dq_q, dr_q, dv_q;
  logic [CntW-1:0]    cnt_q;

  function automatic logic signed [W-1:0] sx(input logic [31:0] v);
    logic [OperandW-1:0] t;
    t = v[OperandW-1:0];
    return W'(signed'(t));
  endfunction

  logic signed [31:0]  ma, mb;
  logic signed [W-1:0] prod, dprod;
  logic signed [W-1:0] sum;
  logic                ovf;
  logic [W:0]          trial;

  always_comb begin
    // first cycle: n-side product, second: the other product
    if (ctrl_i.mul1) begin
      ma = (op_q == rau_pkg::OP_MUL) ? bn_q[31:0] : bd_q[31:0];
      mb = an_q[31:0];
    end else begin
      ma = (op_q == rau_pkg::OP_MUL) ? bd_q[31:0] : bn_q[31:0];
      mb = ad_q[31:0];
    end
    prod = ma * mb;
    // common denominator for add and subtract
    dprod = signed'(ad_q[31:0]) * signed'(bd_q[31:0]);
    sum = (op_q == rau_pkg::OP_SUB) ? x_q - y_q : x_q + y_q;
    ovf = (op_q == rau_pkg::OP_SUB)
        ? (x_q[W-1] != y_q[W-1]) && (sum[W-1] != x_q[W-1])
        : (x_q[W-1] == y_q[W-1]) && (sum[W-1] != x_q[W-1]);
    trial = {dr_q, dq_q[W-1]} - {1'b0, dv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
      cnt_q <= '0;
      fail_q <= 1'b0;
      st_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        op_q <= req_i.op;
        fail_q <= 1'b0;
      end
      if (ctrl_i.mul1) begin
        fail_q <= (ad_q == 0) || (bd_q == 0);
        if ((ad_q == 0) || (bd_q == 0)) st_q <= rau_pkg::ST_ZERO_DEN;
      end
      if (ctrl_i.combine) begin
        if ((op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) && ovf) begin
          fail_q <= 1'b1;
          st_q <= rau_pkg::ST_OVERFLOW;
        end else if (d_q == 0) begin
          fail_q <= 1'b1;
          st_q <= rau_pkg::ST_ZERO_DEN;
        end else begin
          st_q <= rau_pkg::ST_OK;
        end
      end
      if (ctrl_i.gcd_init || ctrl_i.gcd_next || ctrl_i.divn_init || ctrl_i.divd_init) begin
        cnt_q <= '0;
      end else if (ctrl_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      an_q <= sx(req_i.a_num);
      ad_q <= sx(req_i.a_den);
      bn_q <= sx(req_i.b_num);
      bd_q <= sx(req_i.b_den);
    end
    if (ctrl_i.mul1) x_q <= prod;
    if (ctrl_i.mul2) begin
      if (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) y_q <= prod;
      else y_q <= x_q;
      d_q <= (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) ? dprod : prod;
    end
    if (ctrl_i.combine) begin
      logic signed [W-1:0] n;
      n = (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) ? sum : y_q;
      nneg_q <= n[W-1];
      dneg_q <= d_q[W-1];
      mn_q <= n[W-1] ? W'(-n) : W'(n);
      md_q <= d_q[W-1] ? W'(-d_q) : W'(d_q);
    end
    if (ctrl_i.gcd_init) begin
      gx_q <= mn_q;
      gy_q <= md_q;
      dq_q <= mn_q;
      dv_q <= md_q;
      dr_q <= '0;
    end
    if (ctrl_i.div_step) begin
      dq_q <= {dq_q[W-2:0], !trial[W]};
      dr_q <= trial[W] ? {dr_q[W-2:0], dq_q[W-1]} : trial[W-1:0];
    end
    if (ctrl_i.gcd_next) begin
      // x, y <- y, x mod y
      gx_q <= gy_q;
      gy_q <= dr_q;
      dq_q <= gy_q;
      dv_q <= dr_q;
      dr_q <= '0;
    end
    if (ctrl_i.divn_init) begin
      if (gx_q == 0) gx_q <= W'(1);
      dq_q <= mn_q;
      dv_q <= (gx_q == 0) ? W'(1) : gx_q;
      dr_q <= '0;
    end
    if (ctrl_i.divd_init) begin
      mn_q <= dq_q;
      dq_q <= md_q;
      dr_q <= '0;
    end
    if (ctrl_i.finish && !fail_q) begin
      mn_q <= nneg_q ? W'(-mn_q) : mn_q;
      md_q <= dneg_q ? W'(-dq_q) : dq_q;
    end
  end

  always_comb begin
    stat_o.early_exit = (ad_q == 0) || (bd_q == 0);
    stat_o.fail = fail_q;
    stat_o.y_zero = ctrl_i.gcd_init ? (md_q == 0) : (dr_q == 0);
    stat_o.div_last = (cnt_q == CntW'(W - 1));
  end

  // results are presented in the cycle after the finish command
  logic [W-1:0] rn_q, rd_q;
  logic [1:0]   rs_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      rn_q <= fail_q ? '0 : (nneg_q ? W'(-mn_q) : mn_q);
      rd_q <= fail_q ? '0 : (dneg_q ? W'(-dq_q) : dq_q);
      rs_q <= st_q;
    end
  end

  assign rsp_o.res_num = rn_q;
  assign rsp_o.res_den = rd_q;
  assign rsp_o.status  = rs_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |-> dv_q != 0)
    else $error("divide by zero in iterative divider");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish && !fail_q |-> st_q == rau_pkg::ST_OK)
    else $error("status mismatch on success");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish && fail_q |-> st_q != rau_pkg::ST_OK)
    else $error("failure without status");

endmodule

FILE: src/rational_arith_unit_core.sv
// Rational arithmetic unit: add, subtract, multiply or divide two fractions
// and reduce the result by Euclid's gcd on magnitudes.
// Channels: a transaction enters when start is high and busy is low;
// req_i carries the op and the four operands (low OPERAND_WIDTH bits used,
// sign extended). One result per transaction appears on rsp_o, marked by
// done_o high for exactly one cycle. The receiver cannot stall; the result must
// be taken in that cycle.
// Flow: a zero input denominator goes to done straight after the first
// multiply state; overflow or a zero result denominator after the gcd init
// state. Otherwise each Euclid remainder step and the final two divisions run
// on one shared 64-bit restoring divider that retires one quotient bit per cycle.
// One transaction at a time: busy stays high from acceptance until the
// cycle in which done_o is raised; a new transaction may enter in that cycle.
// Reset (async, active low) returns the controller to idle; no transaction
// in flight survives and no result is produced for it.
module rational_arith_unit_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rau_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output rau_pkg::rsp_t rsp_o
);

  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;
  logic           fin;
  logic           done_q;

  rau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy),
    .done_o (fin)
  );

  rau_dp #(.OperandW(OPERAND_WIDTH)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin;
    end
  end

  assign done_o = done_q;

endmodule
